/* hw/rtl/dqd_pkg.sv */
// ============================================================================
// dqd_pkg
// Shared widths, register indexes, reset values and control types for the
// detection query decoder.
// ============================================================================
package dqd_pkg;

    localparam int MAX_CLASSES_DEF = 128;

    localparam int SCORE_W    = 16;
    localparam int COORD_W    = 16;
    localparam int NORM_W     = 18;
    localparam int MAG_W      = 17;
    localparam int DIM_W      = 13;
    localparam int INV_W      = 24;
    localparam int P1_W       = MAG_W + DIM_W;
    localparam int P2_W       = P1_W + INV_W;
    localparam int PIX_W      = 16;
    localparam int LABEL_W    = 7;
    localparam int LIMIT_W    = 8;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 24;
    localparam int S_TDATA_W  = 80;
    localparam int M_TDATA_W  = 88;

    // Rounding offsets and shifts from the product to Q12.4.
    localparam int DIRECT_SHIFT = 11;
    localparam int LEGACY_SHIFT = 27;

    localparam logic [DIM_W-1:0]   IMAGE_WIDTH_RST     = 13'd640;
    localparam logic [DIM_W-1:0]   IMAGE_HEIGHT_RST    = 13'd640;
    localparam logic [DIM_W-1:0]   MODEL_WIDTH_RST     = 13'd640;
    localparam logic [DIM_W-1:0]   MODEL_HEIGHT_RST    = 13'd640;
    localparam logic [INV_W-1:0]   INVERSE_SCALE_RST   = 24'd65536;
    localparam logic [SCORE_W-1:0] SCORE_THRESHOLD_RST = 16'd32768;
    localparam logic [LIMIT_W-1:0] LABEL_LIMIT_RST     = 8'd91;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_DIRECT_MODE     = 3'd0,
        CFG_IMAGE_WIDTH     = 3'd1,
        CFG_IMAGE_HEIGHT    = 3'd2,
        CFG_MODEL_WIDTH     = 3'd3,
        CFG_MODEL_HEIGHT    = 3'd4,
        CFG_INVERSE_SCALE   = 3'd5,
        CFG_SCORE_THRESHOLD = 3'd6,
        CFG_LABEL_LIMIT     = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic       score_en;
        logic       mul1;
        logic       mul2;
        logic       round_en;
        logic       load_out;
        logic [1:0] corner;
    } dqd_cmd_t;

    typedef struct packed {
        logic query_ok;
        logic box_ok;
        logic out_busy;
    } dqd_status_t;

endpackage

/* hw/rtl/dqd_ctrl.sv */
// ============================================================================
// dqd_ctrl
// Sequencer: takes score beats, checks the query, then walks the four
// corners through the shared multiply and round steps and hands off the box.
// ============================================================================
module dqd_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_axis_tvalid,
    input  logic                s_axis_tlast,
    output logic                s_axis_tready,
    input  dqd_pkg::dqd_status_t status,
    output dqd_pkg::dqd_cmd_t   cmd
);

    typedef enum logic [2:0] {
        ST_SCORE,
        ST_CHECK,
        ST_MUL1,
        ST_MUL2,
        ST_ROUND,
        ST_FINAL
    } state_t;

    state_t     state_reg;
    logic [1:0] corner_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_SCORE;
            corner_reg <= 2'd0;
        end else begin
            case (state_reg)
                ST_SCORE: begin
                    if (s_axis_tvalid && s_axis_tlast) begin
                        state_reg <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    corner_reg <= 2'd0;
                    state_reg  <= status.query_ok ? ST_MUL1 : ST_SCORE;
                end
                ST_MUL1: begin
                    state_reg <= ST_MUL2;
                end
                ST_MUL2: begin
                    state_reg <= ST_ROUND;
                end
                ST_ROUND: begin
                    if (corner_reg == 2'd3) begin
                        state_reg <= ST_FINAL;
                    end else begin
                        corner_reg <= corner_reg + 2'd1;
                        state_reg  <= ST_MUL1;
                    end
                end
                ST_FINAL: begin
                    if (!status.out_busy) begin
                        state_reg <= ST_SCORE;
                    end
                end
                default: begin
                    state_reg <= ST_SCORE;
                end
            endcase
        end
    end

    always_comb begin
        s_axis_tready = (state_reg == ST_SCORE);
        cmd.score_en  = (state_reg == ST_SCORE) && s_axis_tvalid;
        cmd.mul1      = (state_reg == ST_MUL1);
        cmd.mul2      = (state_reg == ST_MUL2);
        cmd.round_en  = (state_reg == ST_ROUND);
        cmd.load_out  = (state_reg == ST_FINAL) && !status.out_busy && status.box_ok;
        cmd.corner    = corner_reg;
    end

endmodule

/* hw/rtl/dqd_datapath.sv */
// ============================================================================
// dqd_datapath
// Configuration registers, running argmax, corner arithmetic with a shared
// two-step multiplier, and the output register.
// ============================================================================
module dqd_datapath #(
    parameter int MAX_CLASSES = dqd_pkg::MAX_CLASSES_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [dqd_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [dqd_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic [dqd_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic                             s_tlast,
    input  logic                             m_tready,
    input  dqd_pkg::dqd_cmd_t                cmd,
    output dqd_pkg::dqd_status_t             status,
    output logic                             m_tvalid,
    output logic [dqd_pkg::M_TDATA_W-1:0]    m_tdata
);

    localparam int CW   = $clog2(MAX_CLASSES + 1);
    localparam int IW   = (MAX_CLASSES > 2) ? $clog2(MAX_CLASSES) : 1;
    localparam int CMPW = (IW > dqd_pkg::LIMIT_W) ? IW : dqd_pkg::LIMIT_W;
    localparam int LBW  = (IW > dqd_pkg::LABEL_W) ? IW : dqd_pkg::LABEL_W;
    localparam int RW   = dqd_pkg::P2_W + 1;

    // Configuration registers.
    logic                          direct_mode_reg;
    logic [dqd_pkg::DIM_W-1:0]     image_width_reg;
    logic [dqd_pkg::DIM_W-1:0]     image_height_reg;
    logic [dqd_pkg::DIM_W-1:0]     model_width_reg;
    logic [dqd_pkg::DIM_W-1:0]     model_height_reg;
    logic [dqd_pkg::INV_W-1:0]     inverse_scale_reg;
    logic [dqd_pkg::SCORE_W-1:0]   score_threshold_reg;
    logic [dqd_pkg::LIMIT_W-1:0]   label_limit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            direct_mode_reg     <= 1'b1;
            image_width_reg     <= dqd_pkg::IMAGE_WIDTH_RST;
            image_height_reg    <= dqd_pkg::IMAGE_HEIGHT_RST;
            model_width_reg     <= dqd_pkg::MODEL_WIDTH_RST;
            model_height_reg    <= dqd_pkg::MODEL_HEIGHT_RST;
            inverse_scale_reg   <= dqd_pkg::INVERSE_SCALE_RST;
            score_threshold_reg <= dqd_pkg::SCORE_THRESHOLD_RST;
            label_limit_reg     <= dqd_pkg::LABEL_LIMIT_RST;
        end else if (cfg_we) begin
            case (dqd_pkg::cfg_idx_t'(cfg_addr))
                dqd_pkg::CFG_DIRECT_MODE:
                    direct_mode_reg <= cfg_wdata[0];
                dqd_pkg::CFG_IMAGE_WIDTH:
                    image_width_reg <= cfg_wdata[dqd_pkg::DIM_W-1:0];
                dqd_pkg::CFG_IMAGE_HEIGHT:
                    image_height_reg <= cfg_wdata[dqd_pkg::DIM_W-1:0];
                dqd_pkg::CFG_MODEL_WIDTH:
                    model_width_reg <= cfg_wdata[dqd_pkg::DIM_W-1:0];
                dqd_pkg::CFG_MODEL_HEIGHT:
                    model_height_reg <= cfg_wdata[dqd_pkg::DIM_W-1:0];
                dqd_pkg::CFG_INVERSE_SCALE:
                    inverse_scale_reg <= cfg_wdata[dqd_pkg::INV_W-1:0];
                dqd_pkg::CFG_SCORE_THRESHOLD:
                    score_threshold_reg <= cfg_wdata[dqd_pkg::SCORE_W-1:0];
                dqd_pkg::CFG_LABEL_LIMIT:
                    label_limit_reg <= cfg_wdata[dqd_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // Input beat fields.
    logic [dqd_pkg::SCORE_W-1:0] score;
    assign score = s_tdata[15:0];

    // Running argmax over the scores of one query.
    logic [dqd_pkg::SCORE_W-1:0] running_max_reg;
    logic [IW-1:0]               running_class_reg;
    logic [CW-1:0]               class_counter_reg;
    logic                        counting;
    logic                        take;
    logic [dqd_pkg::SCORE_W-1:0] max_next;
    logic [IW-1:0]               class_next;

    assign counting   = class_counter_reg < CW'(MAX_CLASSES);
    assign take       = counting && (score > running_max_reg);
    assign max_next   = take ? score : running_max_reg;
    assign class_next = take ? class_counter_reg[IW-1:0] : running_class_reg;

    // Query snapshot taken on the last beat.
    logic [dqd_pkg::SCORE_W-1:0] best_reg;
    logic [IW-1:0]               cls_reg;
    logic [dqd_pkg::COORD_W-1:0] cx_reg, cy_reg, bw_reg, bh_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_max_reg   <= '0;
            running_class_reg <= '0;
            class_counter_reg <= '0;
        end else if (cmd.score_en) begin
            if (s_tlast) begin
                running_max_reg   <= '0;
                running_class_reg <= '0;
                class_counter_reg <= '0;
            end else begin
                running_max_reg   <= max_next;
                running_class_reg <= class_next;
                if (counting) begin
                    class_counter_reg <= class_counter_reg + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.score_en && s_tlast) begin
            best_reg <= max_next;
            cls_reg  <= class_next;
            cx_reg   <= s_tdata[31:16];
            cy_reg   <= s_tdata[47:32];
            bw_reg   <= s_tdata[63:48];
            bh_reg   <= s_tdata[79:64];
        end
    end

    logic [CMPW-1:0] cls_cmp;
    assign cls_cmp = CMPW'(cls_reg);
    assign status.query_ok = (best_reg > score_threshold_reg) && (cls_cmp != '0) &&
                             (cls_cmp < CMPW'(label_limit_reg));

    // Corner selection: bit 0 picks the axis, bit 1 picks the far edge.
    logic [dqd_pkg::COORD_W-1:0] ctr_sel, size_sel;
    logic signed [dqd_pkg::NORM_W-1:0] two_c, size_ext, norm;
    logic [dqd_pkg::MAG_W-1:0]   mag;
    logic [dqd_pkg::DIM_W-1:0]   img_dim, mdl_dim;

    always_comb begin
        ctr_sel  = cmd.corner[0] ? cy_reg : cx_reg;
        size_sel = cmd.corner[0] ? bh_reg : bw_reg;
        img_dim  = cmd.corner[0] ? image_height_reg : image_width_reg;
        mdl_dim  = cmd.corner[0] ? model_height_reg : model_width_reg;
        two_c    = {ctr_sel[dqd_pkg::COORD_W-1], ctr_sel, 1'b0};
        size_ext = {{2{size_sel[dqd_pkg::COORD_W-1]}}, size_sel};
        norm     = cmd.corner[1] ? (two_c + size_ext) : (two_c - size_ext);
        // A zero or negative position maps to pixel zero.
        mag      = norm[dqd_pkg::NORM_W-1] ? '0 : norm[dqd_pkg::MAG_W-1:0];
    end

    logic [dqd_pkg::P1_W-1:0] p1_reg;
    logic [dqd_pkg::P2_W-1:0] p2_reg;

    always_ff @(posedge aclk) begin
        if (cmd.mul1) begin
            p1_reg <= dqd_pkg::P1_W'(mag) *
                      dqd_pkg::P1_W'(direct_mode_reg ? img_dim : mdl_dim);
        end
        if (cmd.mul2) begin
            p2_reg <= direct_mode_reg ? dqd_pkg::P2_W'(p1_reg)
                                      : dqd_pkg::P2_W'(p1_reg) *
                                        dqd_pkg::P2_W'(inverse_scale_reg);
        end
    end

    // Round half up to Q12.4, then clamp to the last pixel of the image.
    logic [RW-1:0]              rnd_sum, rounded;
    logic [dqd_pkg::DIM_W+3:0]  lim_wide;
    logic [dqd_pkg::PIX_W-1:0]  lim, clamped;

    always_comb begin
        rnd_sum  = RW'(p2_reg) + (direct_mode_reg ? (RW'(1) << (dqd_pkg::DIRECT_SHIFT - 1))
                                                  : (RW'(1) << (dqd_pkg::LEGACY_SHIFT - 1)));
        rounded  = direct_mode_reg ? (rnd_sum >> dqd_pkg::DIRECT_SHIFT)
                                   : (rnd_sum >> dqd_pkg::LEGACY_SHIFT);
        lim_wide = (img_dim == '0) ? '0 : {img_dim - dqd_pkg::DIM_W'(1), 4'b0000};
        lim      = (lim_wide > (dqd_pkg::DIM_W + 4)'(16'hFFFF)) ? 16'hFFFF
                                                              : lim_wide[dqd_pkg::PIX_W-1:0];
        clamped  = (rounded > RW'(lim)) ? lim : rounded[dqd_pkg::PIX_W-1:0];
    end

    logic [dqd_pkg::PIX_W-1:0] corner_reg [4];

    always_ff @(posedge aclk) begin
        if (cmd.round_en) begin
            corner_reg[cmd.corner] <= clamped;
        end
    end

    // Corners 0/1 are left/top, 2/3 are right/bottom.
    assign status.box_ok = (corner_reg[2] > corner_reg[0]) && (corner_reg[3] > corner_reg[1]);

    logic [LBW-1:0] label_full;
    assign label_full = LBW'(cls_reg) - LBW'(1);

    // Output register.
    logic                          m_valid_reg;
    logic [dqd_pkg::M_TDATA_W-1:0] m_data_reg;

    assign status.out_busy = m_valid_reg && !m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_data_reg <= {1'b0, best_reg, label_full[dqd_pkg::LABEL_W-1:0],
                           corner_reg[3] - corner_reg[1], corner_reg[2] - corner_reg[0],
                           corner_reg[1], corner_reg[0]};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

/* hw/rtl/detection_query_decode.sv */
// ============================================================================
// detection_query_decode
// Reduces one detection query, streamed as class score beats, to at most one
// clamped pixel box with its label and confidence.
// ============================================================================
// Throughput: one score beat per cycle while ready; a query's last beat holds the input off
//   through the check, two multiplies and a round per corner and the hand-off when the query
//   passes, through the check alone when it is rejected. A passing non-empty box is registered
//   at the hand-off, held back only while the previous box still waits on the output.
// Reset: synchronous, active low; clears the argmax state, the output valid
//   and returns the configuration registers to their defaults.
module detection_query_decode #(
    parameter int MAX_CLASSES = dqd_pkg::MAX_CLASSES_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Configuration write port.
    input  logic                           cfg_we,
    input  logic [dqd_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [dqd_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // Score beats.
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // class_score[15:0], mid_x[31:16], mid_y[47:32],
    // box_width[63:48], box_height[79:64]
    input  logic [dqd_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    input  logic                           s_axis_tlast,
    // Box results.
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // left[15:0], top[31:16], extent_x[47:32], extent_y[63:48],
    // label[70:64], confidence[86:71], zero pad[87]
    output logic [dqd_pkg::M_TDATA_W-1:0]  m_axis_tdata
);

    dqd_pkg::dqd_cmd_t    cmd;
    dqd_pkg::dqd_status_t status;

    dqd_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tready (s_axis_tready),
        .status        (status),
        .cmd           (cmd)
    );

    dqd_datapath #(
        .MAX_CLASSES (MAX_CLASSES)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_axis_tdata),
        .s_tlast   (s_axis_tlast),
        .m_tready  (m_axis_tready),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_axis_tvalid),
        .m_tdata   (m_axis_tdata)
    );

endmodule

/* hw/rtl/dqd_checker.sv */
// ============================================================================
// dqd_checker
// Port-level checks on the detection query decoder, bound to the top level.
// ============================================================================
module dqd_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          s_axis_tlast,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [dqd_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    // A stalled result beat holds its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

    // Only non-empty boxes leave the block.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tdata[47:32] != 16'd0) && (m_axis_tdata[63:48] != 16'd0))
    else $error("empty box emitted");

    // The query check after a last beat holds off further input in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("input taken right after a last beat");

    // Reset drops the result valid.
    assert property (@(posedge aclk) !aresetn |=> !m_axis_tvalid)
    else $error("result valid survived reset");

endmodule

bind detection_query_decode dqd_checker u_dqd_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

/* tb/dqd_check_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// dqd_check_pkg
// Box prediction and result checking for the detection query decoder bench.
// Every accepted score beat updates a private copy of the argmax state. A
// query's last beat turns that state and the box fields into the expected
// box, if one is due. Output beats are then checked in order against them.
// ============================================================================
package dqd_check_pkg;
    import dqd_pkg::*;

    typedef struct {
        logic               direct_mode;
        logic [DIM_W-1:0]   image_width;
        logic [DIM_W-1:0]   image_height;
        logic [DIM_W-1:0]   model_width;
        logic [DIM_W-1:0]   model_height;
        logic [INV_W-1:0]   inverse_scale;
        logic [SCORE_W-1:0] score_threshold;
        logic [LIMIT_W-1:0] label_limit;
    } decode_cfg_t;

    typedef struct {
        logic [PIX_W-1:0]   left;
        logic [PIX_W-1:0]   top;
        logic [PIX_W-1:0]   extent_x;
        logic [PIX_W-1:0]   extent_y;
        logic [LABEL_W-1:0] label;
        logic [SCORE_W-1:0] confidence;
    } box_t;

    class box_scoreboard;
        decode_cfg_t        cfg;
        logic [SCORE_W-1:0] best_score;
        int unsigned        top_class;
        int unsigned        score_index;
        box_t               expected_boxes[$];
        int                 errors;

        function new();
            cfg.direct_mode     = 1'b1;
            cfg.image_width     = IMAGE_WIDTH_RST;
            cfg.image_height    = IMAGE_HEIGHT_RST;
            cfg.model_width     = MODEL_WIDTH_RST;
            cfg.model_height    = MODEL_HEIGHT_RST;
            cfg.inverse_scale   = INVERSE_SCALE_RST;
            cfg.score_threshold = SCORE_THRESHOLD_RST;
            cfg.label_limit     = LABEL_LIMIT_RST;
            errors = 0;
            clear_query();
        endfunction

        function void clear_query();
            best_score  = '0;
            top_class   = 0;
            score_index = 0;
        endfunction

        function void write_register(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_DIRECT_MODE:     cfg.direct_mode     = value[0];
                CFG_IMAGE_WIDTH:     cfg.image_width     = value[DIM_W-1:0];
                CFG_IMAGE_HEIGHT:    cfg.image_height    = value[DIM_W-1:0];
                CFG_MODEL_WIDTH:     cfg.model_width     = value[DIM_W-1:0];
                CFG_MODEL_HEIGHT:    cfg.model_height    = value[DIM_W-1:0];
                CFG_INVERSE_SCALE:   cfg.inverse_scale   = value[INV_W-1:0];
                CFG_SCORE_THRESHOLD: cfg.score_threshold = value[SCORE_W-1:0];
                CFG_LABEL_LIMIT:     cfg.label_limit     = value[LIMIT_W-1:0];
                default: ;
            endcase
        endfunction

        // A corner in Q.15 becomes a Q12.4 pixel position, rounded half up.
        function longint unsigned scale_edge(int norm, logic [DIM_W-1:0] img,
                                             logic [DIM_W-1:0] mdl);
            longint unsigned mag;
            longint unsigned prod;
            if (norm <= 0) return 0;
            mag = norm;
            if (cfg.direct_mode) begin
                prod = mag * img;
                return (prod + (64'd1 << (DIRECT_SHIFT - 1))) >> DIRECT_SHIFT;
            end
            prod = mag * mdl * cfg.inverse_scale;
            return (prod + (64'd1 << (LEGACY_SHIFT - 1))) >> LEGACY_SHIFT;
        endfunction

        function longint unsigned edge_limit(logic [DIM_W-1:0] img);
            longint unsigned lim;
            if (img == 0) return 0;
            lim = (longint'(img) - 1) * 16;
            return (lim > 65535) ? 65535 : lim;
        endfunction

        function void note_score_beat(logic [SCORE_W-1:0] score, logic last,
                                      logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy,
                                      logic [COORD_W-1:0] bw, logic [COORD_W-1:0] bh);
            logic [SCORE_W-1:0] best;
            int unsigned        cls;
            longint unsigned    lim_x, lim_y, x1, y1, x2, y2;
            box_t               box;
            if (score_index < MAX_CLASSES_DEF) begin
                if (score > best_score) begin
                    best_score = score;
                    top_class  = score_index;
                end
                score_index++;
            end
            if (!last) return;
            best = best_score;
            cls  = top_class;
            clear_query();
            if (!(best > cfg.score_threshold && cls > 0 && cls < cfg.label_limit)) return;

            lim_x = edge_limit(cfg.image_width);
            lim_y = edge_limit(cfg.image_height);
            x1 = scale_edge(2 * int'($signed(cx)) - int'($signed(bw)),
                            cfg.image_width, cfg.model_width);
            y1 = scale_edge(2 * int'($signed(cy)) - int'($signed(bh)),
                            cfg.image_height, cfg.model_height);
            x2 = scale_edge(2 * int'($signed(cx)) + int'($signed(bw)),
                            cfg.image_width, cfg.model_width);
            y2 = scale_edge(2 * int'($signed(cy)) + int'($signed(bh)),
                            cfg.image_height, cfg.model_height);
            if (x1 > lim_x) x1 = lim_x;
            if (y1 > lim_y) y1 = lim_y;
            if (x2 > lim_x) x2 = lim_x;
            if (y2 > lim_y) y2 = lim_y;
            if (x2 < x1) x2 = x1;
            if (y2 < y1) y2 = y1;
            if (x2 <= x1 || y2 <= y1) return;

            box.left       = PIX_W'(x1);
            box.top        = PIX_W'(y1);
            box.extent_x   = PIX_W'(x2 - x1);
            box.extent_y   = PIX_W'(y2 - y1);
            box.label      = LABEL_W'(cls - 1);
            box.confidence = best;
            expected_boxes.insert(expected_boxes.size(), box);
        endfunction

        function void check_field(string name, longint unsigned want, longint unsigned got);
            if (want != got) begin
                $error("%s mismatch: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_box_beat(logic [M_TDATA_W-1:0] beat);
            box_t want;
            if (expected_boxes.size() == 0) begin
                $error("box beat with no box expected: %h", beat);
                errors++;
                return;
            end
            want = expected_boxes.pop_front();
            check_field("left", want.left, beat[15:0]);
            check_field("top", want.top, beat[31:16]);
            check_field("extent_x", want.extent_x, beat[47:32]);
            check_field("extent_y", want.extent_y, beat[63:48]);
            check_field("label", want.label, beat[70:64]);
            check_field("confidence", want.confidence, beat[86:71]);
        endfunction
    endclass

endpackage

/* tb/detection_query_decode_test.sv */
`timescale 1ns / 1ps
// ============================================================================
// detection_query_decode_test
// Self-checking bench for the detection query decoder. A short directed run
// covers ties, the background class, threshold edges, clamping and zero or
// oversized images; random queries then run under several register settings
// while both stream sides idle at random and the output is held off once.
// ============================================================================
module detection_query_decode_test;
    import dqd_pkg::*;
    import dqd_check_pkg::*;

    localparam int SETTLE_CYCLES = 40;    // well past the time a box needs to come out
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASE_BEATS   = 265;
    localparam int PHASES        = 6;
    localparam int DRAIN_LIMIT   = 20000;

    localparam logic [COORD_W-1:0] CENTER = 16'd8192;     // 0.5 in Q2.14
    localparam logic [COORD_W-1:0] UNIT   = 16'd16384;    // 1.0 in Q2.14

    typedef enum int {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_PERIODIC} ready_mode_t;
    typedef enum int {SET_RESET, SET_DIRECT, SET_LEGACY, SET_EXTREME} setting_kind_t;

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  cfg_we        = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr      = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata     = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                  s_axis_tlast  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;

    box_scoreboard sb;
    int            burst_left = 0;
    int            beats_sent = 0;
    bit            hold_req   = 1'b0;

    setting_kind_t phase_plan[PHASES] = '{SET_RESET, SET_DIRECT, SET_LEGACY,
                                          SET_EXTREME, SET_DIRECT, SET_LEGACY};

    detection_query_decode dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            sb.check_box_beat(m_axis_tdata);
        end
    end

    // Output side: segments of different ready patterns, plus one long hold.
    initial begin : receiver
        ready_mode_t mode;
        int          seg_left;
        int          hold_left;
        int          tick;
        mode      = READY_ALWAYS;
        seg_left  = 0;
        hold_left = 0;
        tick      = 0;
        forever begin
            @(negedge aclk);
            tick++;
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (seg_left == 0) begin
                mode     = ready_mode_t'($urandom_range(0, 3));
                seg_left = $urandom_range(20, 200);
            end
            seg_left--;
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                case (mode)
                    READY_ALWAYS: m_axis_tready <= 1'b1;
                    READY_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
                    READY_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default:      m_axis_tready <= (tick % 5 < 2);
                endcase
            end
        end
    end

    // Called at a falling edge; returns at a falling edge after the beat is taken.
    task automatic send_beat(input logic [SCORE_W-1:0] score, input logic last,
                             input logic [COORD_W-1:0] cx, input logic [COORD_W-1:0] cy,
                             input logic [COORD_W-1:0] bw, input logic [COORD_W-1:0] bh);
        s_axis_tdata  <= {bh, bw, cy, cx, score};
        s_axis_tlast  <= last;
        s_axis_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        sb.note_score_beat(score, last, cx, cy, bw, bh);
        beats_sent++;
        @(negedge aclk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge aclk);
            burst_left = ($urandom_range(0, 9) == 0) ? 300 : $urandom_range(0, 30);
        end
    endtask

    // The box fields of a beat that is not last are ignored, so they carry noise.
    task automatic send_score(input logic [SCORE_W-1:0] score);
        send_beat(score, 1'b0, COORD_W'($urandom), COORD_W'($urandom),
                  COORD_W'($urandom), COORD_W'($urandom));
    endtask

    task automatic send_random_query();
        int               n;
        int               peak_at;
        logic [SCORE_W-1:0] peak;
        if ($urandom_range(0, 99) < 80) begin
            n = ($urandom_range(0, 99) < 3) ? $urandom_range(120, 200) : $urandom_range(1, 12);
            peak_at = $urandom_range(0, n - 1);
            peak = SCORE_W'($urandom_range(40000, 65535));
            for (int i = 0; i < n - 1; i++) begin
                send_score((i == peak_at) ? peak : SCORE_W'($urandom_range(0, 49999)));
            end
            send_beat((peak_at == n - 1) ? peak : SCORE_W'($urandom_range(0, 49999)), 1'b1,
                      COORD_W'($urandom_range(0, 16384)), COORD_W'($urandom_range(0, 16384)),
                      COORD_W'($urandom_range(0, 16384)), COORD_W'($urandom_range(0, 16384)));
        end else begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++) begin
                send_beat(SCORE_W'($urandom), (i == n - 1), COORD_W'($urandom),
                          COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom));
            end
        end
    endtask

    // Leaves the write enable high; apply_config lowers it after the last write.
    task automatic cfg_write(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        sb.write_register(idx, value);
        @(negedge aclk);
    endtask

    task automatic apply_config(input decode_cfg_t c);
        cfg_write(CFG_DIRECT_MODE, CFG_DATA_W'(c.direct_mode));
        cfg_write(CFG_IMAGE_WIDTH, CFG_DATA_W'(c.image_width));
        cfg_write(CFG_IMAGE_HEIGHT, CFG_DATA_W'(c.image_height));
        cfg_write(CFG_MODEL_WIDTH, CFG_DATA_W'(c.model_width));
        cfg_write(CFG_MODEL_HEIGHT, CFG_DATA_W'(c.model_height));
        cfg_write(CFG_INVERSE_SCALE, CFG_DATA_W'(c.inverse_scale));
        cfg_write(CFG_SCORE_THRESHOLD, CFG_DATA_W'(c.score_threshold));
        cfg_write(CFG_LABEL_LIMIT, CFG_DATA_W'(c.label_limit));
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.expected_boxes.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    function automatic decode_cfg_t pick_settings(setting_kind_t kind);
        decode_cfg_t c;
        case (kind)
            SET_RESET: begin
                c = '{direct_mode: 1'b1, image_width: IMAGE_WIDTH_RST,
                      image_height: IMAGE_HEIGHT_RST, model_width: MODEL_WIDTH_RST,
                      model_height: MODEL_HEIGHT_RST, inverse_scale: INVERSE_SCALE_RST,
                      score_threshold: SCORE_THRESHOLD_RST, label_limit: LABEL_LIMIT_RST};
            end
            SET_DIRECT: begin
                c.direct_mode     = 1'b1;
                c.image_width     = DIM_W'($urandom_range(1, 4096));
                c.image_height    = DIM_W'($urandom_range(1, 4096));
                c.model_width     = DIM_W'($urandom_range(0, 8191));
                c.model_height    = DIM_W'($urandom_range(0, 8191));
                c.inverse_scale   = INV_W'($urandom);
                c.score_threshold = SCORE_W'($urandom_range(0, 45000));
                c.label_limit     = LIMIT_W'($urandom_range(2, 128));
            end
            SET_LEGACY: begin
                c.direct_mode     = 1'b0;
                c.image_width     = DIM_W'($urandom_range(1, 4096));
                c.image_height    = DIM_W'($urandom_range(1, 4096));
                c.model_width     = DIM_W'($urandom_range(1, 4096));
                c.model_height    = DIM_W'($urandom_range(1, 4096));
                c.inverse_scale   = INV_W'($urandom_range(24'h004000, 24'h040000));
                c.score_threshold = SCORE_W'($urandom_range(0, 45000));
                c.label_limit     = LIMIT_W'($urandom_range(2, 128));
            end
            default: begin
                // Edge limits saturate on x; legacy y scales almost to nothing.
                c.direct_mode     = 1'($urandom_range(0, 1));
                c.image_width     = 13'd8191;
                c.image_height    = DIM_W'($urandom_range(4097, 8191));
                c.model_width     = 13'd8191;
                c.model_height    = 13'd1;
                c.inverse_scale   = 24'hFFFFFF;
                c.score_threshold = 16'd0;
                c.label_limit     = 8'd255;
            end
        endcase
        return c;
    endfunction

    initial begin : stimulus
        int phase_start;
        int drain_wait;
        bit paused;
        paused = 1'b0;
        sb = new();
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed queries on the reset settings.
        send_beat(16'hFFFF, 1'b1, CENTER, CENTER, UNIT, UNIT);
        send_score(16'd0);
        send_beat(16'hFFFF, 1'b1, CENTER, CENTER, UNIT, UNIT);
        send_score(16'd100);
        send_beat(SCORE_THRESHOLD_RST, 1'b1, CENTER, CENTER, UNIT, UNIT);
        // A tie keeps the earlier class; the negative y range leaves the box empty.
        send_score(16'd0);
        send_score(16'd40000);
        send_beat(16'd40000, 1'b1, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
        send_score(16'd0);
        send_beat(16'd50000, 1'b1, 16'd4096, 16'd4096, 16'd0, 16'd100);
        send_score(16'd0);
        send_score(16'd1);
        send_beat(16'd60000, 1'b1, CENTER, CENTER, 16'h7FFF, 16'h7FFF);
        send_score(16'd0);
        send_beat(16'd33000, 1'b1, 16'd100, 16'd16000, 16'd50, 16'd300);

        // Oversized image with legacy scaling at full inverse scale.
        wait_drained();
        apply_config('{direct_mode: 1'b0, image_width: 13'd8191, image_height: 13'd8191,
                       model_width: 13'd4096, model_height: 13'd8191,
                       inverse_scale: 24'hFFFFFF, score_threshold: 16'd0,
                       label_limit: 8'd128});
        send_score(16'd0);
        send_beat(16'd1, 1'b1, CENTER, CENTER, UNIT, UNIT);
        send_score(16'd0);
        send_beat(16'd0, 1'b1, CENTER, CENTER, UNIT, UNIT);

        // Zero image width, and a class that reaches the label limit.
        wait_drained();
        apply_config('{direct_mode: 1'b1, image_width: 13'd0, image_height: 13'd8191,
                       model_width: 13'd1, model_height: 13'd0, inverse_scale: 24'd0,
                       score_threshold: 16'd65534, label_limit: 8'd2});
        send_score(16'd0);
        send_beat(16'hFFFF, 1'b1, CENTER, CENTER, UNIT, UNIT);
        send_score(16'd0);
        send_score(16'd0);
        send_beat(16'hFFFF, 1'b1, CENTER, CENTER, UNIT, UNIT);

        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            apply_config(pick_settings(phase_plan[p]));
            if (p == 2) hold_req = 1'b1;
            phase_start = beats_sent;
            while (beats_sent - phase_start < PHASE_BEATS) begin
                send_random_query();
                if (p == 3 && !paused && beats_sent - phase_start > PHASE_BEATS / 2) begin
                    wait_drained();
                    paused = 1'b1;
                end
            end
        end

        s_axis_tvalid <= 1'b0;
        drain_wait = 0;
        while (sb.expected_boxes.size() != 0 && drain_wait < DRAIN_LIMIT) begin
            @(negedge aclk);
            drain_wait++;
        end
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (sb.expected_boxes.size() != 0) begin
            $error("%0d expected boxes never arrived", sb.expected_boxes.size());
            sb.errors++;
        end
        if (sb.errors == 0) begin
            $display("detection_query_decode_test: PASS");
        end else begin
            $display("detection_query_decode_test: FAIL");
        end
        $finish;
    end

    initial begin : watchdog
        #2000000;
        $display("detection_query_decode_test: FAIL");
        $finish;
    end

endmodule
